FILE: hdl/chi_pkg.sv
// Package for the chained hash index: shared widths, operation codes and the
// command/status structs between controller and datapath. No dependencies.
package chi_pkg;

    localparam int KEY_W   = 32;
    localparam int ENTRY_W = 12;
    localparam int SLOT_W  = ENTRY_W + 1;   // valid flag plus entry number
    localparam int SIZE_W  = 13;
    localparam int CNT_W   = 32;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_NEXT  = 2'd2,
        MODE_NOP   = 2'd3
    } chi_mode_t;

    typedef struct packed {
        logic load;
        logic mod_start;
        logic head_rd;
        logic link_rd;
        logic finish;
    } chi_cmd_t;

    typedef struct packed {
        logic clearing;
        logic mod_done;
        logic in_range;
    } chi_sts_t;

endpackage

FILE: hdl/chi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chi_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/chi_mod.sv
// Bucket hash unit: |key| mod BUCKETS. A mask for a power-of-two bucket count,
// otherwise a restoring remainder, four bits a cycle. Depends on chi_pkg.
module chi_mod
    import chi_pkg::*;
#(
    parameter int BUCKETS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [KEY_W-1:0]    key,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] bucket
);

    localparam int BW   = $clog2(BUCKETS);
    localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    logic [KEY_W-1:0] key_u;
    logic [KEY_W-1:0] mag;

    assign key_u = key;
    assign mag   = key_u[KEY_W-1] ? (~key_u + KEY_W'(1)) : key_u;

    generate
        if (POW2)
        begin : g_mask
            logic          done_reg;
            logic [BW-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= mag[BW-1:0];
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
        else
        begin : g_serial
            localparam int RW     = BW + 1;
            localparam int DIGITS = 4;
            localparam int STEPS  = KEY_W / DIGITS;
            localparam int CW     = $clog2(STEPS);

            logic              run_reg;
            logic              done_reg;
            logic [CW-1:0]     cnt_reg;
            logic [RW-1:0]     rem_reg;
            logic [KEY_W-1:0]  quo_reg;
            logic [RW-1:0]     rem_next;
            logic [KEY_W-1:0]  quo_next;

            always_comb
            begin
                rem_next = rem_reg;
                quo_next = quo_reg;
                for (int i = 0; i < DIGITS; i++)
                begin
                    rem_next = {rem_next[RW-2:0], quo_next[KEY_W-1]};
                    quo_next = {quo_next[KEY_W-2:0], 1'b0};
                    if (rem_next >= RW'(BUCKETS))
                    begin
                        rem_next = rem_next - RW'(BUCKETS);
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        run_reg <= 1'b1;
                        cnt_reg <= '0;
                    end
                    else if (run_reg)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        if (cnt_reg == CW'(STEPS - 1))
                        begin
                            run_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= '0;
                    quo_reg <= mag;
                end
                else if (run_reg)
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg[BW-1:0];
        end
    endgenerate

endmodule

FILE: hdl/chi_ctrl.sv
// Operation sequencer for the chained hash index.
// Drives the datapath by command struct and reads its status. Depends on chi_pkg.
module chi_ctrl
    import chi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  mode,
    input  chi_sts_t    sts,
    output chi_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !sts.clearing)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FIN;
                    unique case (chi_mode_t'(mode))
                        MODE_ADD:
                        begin
                            if (sts.in_range)
                            begin
                                cmd.mod_start = 1'b1;
                                state_next    = S_HASH;
                            end
                        end
                        MODE_FIRST:
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_HASH;
                        end
                        MODE_NEXT:
                        begin
                            cmd.link_rd = sts.in_range;
                        end
                        MODE_NOP:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                if (sts.mod_done)
                begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || sts.clearing;

endmodule

FILE: hdl/chi_dpath.sv
// Datapath for the chained hash index: head and link stores, clearing sweeps,
// table size register, counters and result registers.
// Depends on chi_pkg, chi_ram and chi_mod.
module chi_dpath
    import chi_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int ENTRIES = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  chi_cmd_t                 cmd,
    output chi_sts_t                 sts,
    input  logic [1:0]               mode,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [ENTRY_W-1:0]       index,
    input  logic                     cfg_we,
    input  logic [SIZE_W-1:0]        cfg_wdata,
    output logic                     done,
    output logic                     found,
    output logic [ENTRY_W-1:0]       entry,
    output logic                     error,
    output logic [CNT_W-1:0]         adds_to_empty,
    output logic [CNT_W-1:0]         adds_to_chain,
    output logic [CNT_W-1:0]         first_lookups,
    output logic [CNT_W-1:0]         next_lookups
);

    localparam int BW      = $clog2(BUCKETS);
    localparam int LW      = $clog2(ENTRIES);
    localparam int HCW     = $clog2(BUCKETS + 1);
    localparam int SizeCap = (ENTRIES >= (1 << SIZE_W)) ? (1 << SIZE_W) - 1 : ENTRIES;
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(SizeCap);

    chi_mode_t            mode_reg;
    logic [ENTRY_W-1:0]   idx_reg;
    logic                 err_reg;

    logic [SIZE_W-1:0]    ts_reg;
    logic [SIZE_W-1:0]    ts_next;
    logic [SIZE_W-1:0]    lclr_ptr_reg;
    logic [SIZE_W-1:0]    lclr_ptr_next;
    logic [SIZE_W-1:0]    lclr_end_reg;
    logic [SIZE_W-1:0]    lclr_end_next;
    logic [SIZE_W-1:0]    lclr_step;
    logic [SIZE_W-1:0]    cfg_v;
    logic                 grow;
    logic                 link_clearing;
    logic [HCW-1:0]       hclr_reg;
    logic                 head_clearing;

    logic                 done_reg;
    logic                 found_reg;
    logic [ENTRY_W-1:0]   entry_reg;
    logic                 error_reg;
    logic [CNT_W-1:0]     cnt_new_reg;
    logic [CNT_W-1:0]     cnt_chain_reg;
    logic [CNT_W-1:0]     cnt_first_reg;
    logic [CNT_W-1:0]     cnt_next_reg;

    logic                 mod_done;
    logic [BW-1:0]        bucket;

    logic                 head_we;
    logic [BW-1:0]        head_waddr;
    logic [SLOT_W-1:0]    head_wdata;
    logic [SLOT_W-1:0]    head_rdata;
    logic                 link_we;
    logic [LW-1:0]        link_waddr;
    logic [SLOT_W-1:0]    link_wdata;
    logic [SLOT_W-1:0]    link_rdata;
    logic                 commit_add;

    chi_mod #(.BUCKETS(BUCKETS)) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mod_start),
        .key    (key),
        .done   (mod_done),
        .bucket (bucket)
    );

    chi_ram #(.WIDTH(SLOT_W), .DEPTH(BUCKETS)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (cmd.head_rd),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    chi_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (cmd.link_rd),
        .raddr (LW'(index)),
        .rdata (link_rdata)
    );

    assign head_clearing = hclr_reg != HCW'(BUCKETS);
    assign link_clearing = lclr_ptr_reg < lclr_end_reg;

    assign sts.clearing  = head_clearing || link_clearing;
    assign sts.mod_done  = mod_done;
    assign sts.in_range  = {1'b0, index} < ts_reg;

    assign commit_add = cmd.finish && (mode_reg == MODE_ADD) && !err_reg;

    // stores: a sweep has the write port, otherwise the add commits
    always_comb
    begin
        head_we    = head_clearing || commit_add;
        head_waddr = head_clearing ? hclr_reg[BW-1:0] : bucket;
        head_wdata = head_clearing ? '0 : {1'b1, idx_reg};
        link_we    = link_clearing || commit_add;
        link_waddr = link_clearing ? LW'(lclr_ptr_reg) : LW'(idx_reg);
        link_wdata = link_clearing ? '0 : head_rdata;
    end

    // table size and the pending link sweep; growth extends the sweep range
    always_comb
    begin
        cfg_v         = (cfg_wdata > SIZE_MAX) ? SIZE_MAX : cfg_wdata;
        grow          = cfg_we && (cfg_v > ts_reg);
        lclr_step     = link_clearing ? lclr_ptr_reg + SIZE_W'(1) : lclr_ptr_reg;
        ts_next       = cfg_we ? cfg_v : ts_reg;
        lclr_ptr_next = lclr_step;
        lclr_end_next = lclr_end_reg;
        if (grow)
        begin
            lclr_ptr_next = (link_clearing && (lclr_step < ts_reg)) ? lclr_step : ts_reg;
            lclr_end_next = (link_clearing && (lclr_end_reg > cfg_v)) ? lclr_end_reg : cfg_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg        <= SIZE_MAX;
            lclr_ptr_reg  <= '0;
            lclr_end_reg  <= SIZE_MAX;
            hclr_reg      <= '0;
            done_reg      <= 1'b0;
            cnt_new_reg   <= '0;
            cnt_chain_reg <= '0;
            cnt_first_reg <= '0;
            cnt_next_reg  <= '0;
        end
        else
        begin
            ts_reg       <= ts_next;
            lclr_ptr_reg <= lclr_ptr_next;
            lclr_end_reg <= lclr_end_next;
            if (head_clearing)
            begin
                hclr_reg <= hclr_reg + HCW'(1);
            end
            done_reg <= cmd.finish;
            if (cmd.finish && !err_reg)
            begin
                unique case (mode_reg)
                    MODE_ADD:
                    begin
                        if (head_rdata[SLOT_W-1])
                        begin
                            cnt_chain_reg <= cnt_chain_reg + CNT_W'(1);
                        end
                        else
                        begin
                            cnt_new_reg <= cnt_new_reg + CNT_W'(1);
                        end
                    end
                    MODE_FIRST:
                    begin
                        cnt_first_reg <= cnt_first_reg + CNT_W'(1);
                    end
                    MODE_NEXT:
                    begin
                        cnt_next_reg <= cnt_next_reg + CNT_W'(1);
                    end
                    MODE_NOP:
                    begin
                        cnt_next_reg <= cnt_next_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= chi_mode_t'(mode);
            idx_reg  <= index;
            err_reg  <= ((chi_mode_t'(mode) == MODE_ADD) || (chi_mode_t'(mode) == MODE_NEXT))
                        && !sts.in_range;
        end
        if (cmd.finish)
        begin
            error_reg <= err_reg;
            found_reg <= 1'b0;
            entry_reg <= '0;
            if (!err_reg)
            begin
                unique case (mode_reg)
                    MODE_FIRST:
                    begin
                        found_reg <= head_rdata[SLOT_W-1];
                        entry_reg <= head_rdata[SLOT_W-1] ? head_rdata[ENTRY_W-1:0] : '0;
                    end
                    MODE_NEXT:
                    begin
                        found_reg <= link_rdata[SLOT_W-1];
                        entry_reg <= link_rdata[SLOT_W-1] ? link_rdata[ENTRY_W-1:0] : '0;
                    end
                    MODE_ADD, MODE_NOP:
                    begin
                        found_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign done          = done_reg;
    assign found         = found_reg;
    assign entry         = entry_reg;
    assign error         = error_reg;
    assign adds_to_empty = cnt_new_reg;
    assign adds_to_chain = cnt_chain_reg;
    assign first_lookups = cnt_first_reg;
    assign next_lookups  = cnt_next_reg;

endmodule

FILE: hdl/chained_hash_index_top.sv
// Top level of the chained hash index: controller and datapath.
// Depends on chi_pkg, chi_ctrl and chi_dpath.
//
// Separate-chaining hash index. A transaction is accepted when start is high
// and busy is low; its one result appears on the result ports for exactly one
// cycle with done high, and cannot be held off. Add and get-first pass through
// the hash unit: a mask when BUCKETS is a power of two, otherwise a serial
// remainder, four key bits a cycle. Get-next, out-of-range and ignored
// transactions skip it. An add or get-first reads the head RAM, a get-next the
// link RAM, both registered; an add then writes back both stores. After reset
// the block is busy while both stores are swept to empty. Raising table_size
// sweeps the newly opened links, one a cycle, with busy high; write table_size
// only while no transaction is in flight. Values above ENTRIES saturate.
module chained_hash_index_top
    import chi_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int ENTRIES = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               mode,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [ENTRY_W-1:0]       index,
    input  logic                     cfg_we,
    input  logic [SIZE_W-1:0]        cfg_wdata,
    output logic                     done,
    output logic                     found,
    output logic [ENTRY_W-1:0]       entry,
    output logic                     error,
    output logic [CNT_W-1:0]         adds_to_empty,
    output logic [CNT_W-1:0]         adds_to_chain,
    output logic [CNT_W-1:0]         first_lookups,
    output logic [CNT_W-1:0]         next_lookups
);

    chi_cmd_t cmd;
    chi_sts_t sts;

    chi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    chi_dpath #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (mode),
        .key           (key),
        .index         (index),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .found         (found),
        .entry         (entry),
        .error         (error),
        .adds_to_empty (adds_to_empty),
        .adds_to_chain (adds_to_chain),
        .first_lookups (first_lookups),
        .next_lookups  (next_lookups)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result delivered the cycle after a transaction was accepted");

    a_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (error || !found)) |-> (entry == '0) && !(error && found))
        else $error("entry or found set on an empty or rejected result");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable({adds_to_empty, adds_to_chain, first_lookups, next_lookups}))
        else $error("operation counter changed without a result");

endmodule

FILE: verif/chained_hash_index_top_tb.sv
`timescale 1ns / 1ps
// Testbench for chained_hash_index_top: drives add, get-first and get-next transactions
// and checks each result against a behavioural copy of the bucket and link stores.
// Depends on chi_pkg and the chained_hash_index_top RTL.
module chained_hash_index_top_tb;
    import chi_pkg::*;

    localparam int N_BUCKETS   = 1024;
    localparam int N_ENTRIES   = 4096;
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        chi_mode_t                op_mode;
        logic signed [KEY_W-1:0]  op_key;
        logic [ENTRY_W-1:0]       op_index;
    } hash_op_t;

    typedef struct packed {
        logic               found;
        logic [ENTRY_W-1:0] entry;
        logic               error;
        logic [CNT_W-1:0]   adds_to_empty;
        logic [CNT_W-1:0]   adds_to_chain;
        logic [CNT_W-1:0]   first_lookups;
        logic [CNT_W-1:0]   next_lookups;
    } chain_reply_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              mode = 2'd0;
    logic signed [KEY_W-1:0] key = '0;
    logic [ENTRY_W-1:0]      index = '0;
    logic                    cfg_we = 1'b0;
    logic [SIZE_W-1:0]       cfg_wdata = '0;
    logic                    done;
    logic                    found;
    logic [ENTRY_W-1:0]      entry;
    logic                    error;
    logic [CNT_W-1:0]        adds_to_empty;
    logic [CNT_W-1:0]        adds_to_chain;
    logic [CNT_W-1:0]        first_lookups;
    logic [CNT_W-1:0]        next_lookups;

    // behavioural copy of the index
    bit [ENTRY_W-1:0] head_slot [N_BUCKETS];
    bit               head_live [N_BUCKETS];
    bit [ENTRY_W-1:0] next_slot [N_ENTRIES];
    bit               next_live [N_ENTRIES];
    bit [CNT_W-1:0]   n_new_chain = '0;
    bit [CNT_W-1:0]   n_chained = '0;
    bit [CNT_W-1:0]   n_first = '0;
    bit [CNT_W-1:0]   n_next = '0;
    bit [SIZE_W-1:0]  live_size = SIZE_W'(N_ENTRIES);

    hash_op_t     hash_ops [$];
    chain_reply_t chain_replies [$];
    int unsigned  ops_accepted = 0;
    int unsigned  mismatches = 0;
    int unsigned  stall_cycles = 0;

    bit [SIZE_W-1:0] phase_sizes [8] = '{13'd1, 13'd2, 13'd37, 13'd4095,
                                         13'd300, 13'd4096, 13'd1024, 13'd5000};

    chained_hash_index_top #(
        .BUCKETS(N_BUCKETS),
        .ENTRIES(N_ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .key(key),
        .index(index),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .found(found),
        .entry(entry),
        .error(error),
        .adds_to_empty(adds_to_empty),
        .adds_to_chain(adds_to_chain),
        .first_lookups(first_lookups),
        .next_lookups(next_lookups)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int unsigned key_bucket(input logic signed [KEY_W-1:0] k);
        bit [KEY_W-1:0] mag;
        mag = k[KEY_W-1] ? -k : k;
        return mag % N_BUCKETS;
    endfunction

    function automatic chain_reply_t apply_hash_op(input hash_op_t op);
        chain_reply_t r;
        int unsigned  b;
        r = '0;
        b = key_bucket(op.op_key);
        case (op.op_mode)
            MODE_ADD:
                if (op.op_index >= live_size)
                    r.error = 1'b1;
                else
                begin
                    if (head_live[b])
                        n_chained++;
                    else
                        n_new_chain++;
                    next_slot[op.op_index] = head_slot[b];
                    next_live[op.op_index] = head_live[b];
                    head_slot[b] = op.op_index;
                    head_live[b] = 1'b1;
                end
            MODE_FIRST:
            begin
                n_first++;
                r.found = head_live[b];
                r.entry = head_live[b] ? head_slot[b] : '0;
            end
            MODE_NEXT:
                if (op.op_index >= live_size)
                    r.error = 1'b1;
                else
                begin
                    n_next++;
                    r.found = next_live[op.op_index];
                    r.entry = next_live[op.op_index] ? next_slot[op.op_index] : '0;
                end
            default: ;
        endcase
        r.adds_to_empty = n_new_chain;
        r.adds_to_chain = n_chained;
        r.first_lookups = n_first;
        r.next_lookups  = n_next;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    task automatic push_op(input chi_mode_t m, input logic signed [KEY_W-1:0] k,
                           input logic [ENTRY_W-1:0] i);
        hash_op_t op;
        op.op_mode  = m;
        op.op_key   = k;
        op.op_index = i;
        hash_ops.push_back(op);
    endtask

    task automatic wait_until_drained();
        @(posedge clk);
        while (hash_ops.size() != 0 || start || chain_replies.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_table_size(input bit [SIZE_W-1:0] v);
        bit [SIZE_W-1:0] sat;
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sat = (v > N_ENTRIES) ? SIZE_W'(N_ENTRIES) : v;
        // growth reopens links as empty
        for (int i = live_size; i < sat; i++)
        begin
            next_slot[i] = '0;
            next_live[i] = 1'b0;
        end
        live_size = sat;
        repeat (2) @(posedge clk);
    endtask

    task automatic queue_random_ops(input int unsigned n);
        logic signed [KEY_W-1:0] pool [8];
        logic [ENTRY_W-1:0]      recent [$];
        hash_op_t                op;
        int unsigned             pick;
        // mirrored keys share a bucket
        for (int i = 0; i < 4; i++)
        begin
            pool[i]     = $urandom;
            pool[i + 4] = -pool[i];
        end
        repeat (n)
        begin
            pick = $urandom_range(99);
            op.op_key = ($urandom_range(3) != 0) ? pool[$urandom_range(7)] : $urandom;
            if (live_size != 0 && $urandom_range(99) < 85)
                op.op_index = ENTRY_W'($urandom_range(live_size - 1));
            else
                op.op_index = ENTRY_W'($urandom_range(N_ENTRIES - 1));
            if (pick < 40)
            begin
                op.op_mode = MODE_ADD;
                recent.push_back(op.op_index);
                if (recent.size() > 16)
                    void'(recent.pop_front());
            end
            else if (pick < 65)
                op.op_mode = MODE_FIRST;
            else if (pick < 95)
            begin
                op.op_mode = MODE_NEXT;
                // walk chains built earlier in the phase
                if (recent.size() > 0 && $urandom_range(99) < 60)
                    op.op_index = recent[$urandom_range(recent.size() - 1)];
            end
            else
                op.op_mode = MODE_NOP;
            hash_ops.push_back(op);
        end
    endtask

    // driver
    always @(posedge clk)
    begin : drive_ops
        hash_op_t    op;
        int unsigned idle_pct;
        idle_pct = (ops_accepted >= 600 && ops_accepted < 900) ? 0 : 15;
        if (rst_n && (!start || busy === 1'b0))
        begin
            if (hash_ops.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                op = hash_ops.pop_front();
                start <= 1'b1;
                mode  <= op.op_mode;
                key   <= op.op_key;
                index <= op.op_index;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : observe
        chain_reply_t want;
        hash_op_t     op;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (chain_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no transaction outstanding");
                end
                else
                begin
                    want = chain_replies.pop_front();
                    check_field("found", CNT_W'(want.found), CNT_W'(found));
                    check_field("entry", CNT_W'(want.entry), CNT_W'(entry));
                    check_field("error", CNT_W'(want.error), CNT_W'(error));
                    check_field("adds_to_empty", want.adds_to_empty, adds_to_empty);
                    check_field("adds_to_chain", want.adds_to_chain, adds_to_chain);
                    check_field("first_lookups", want.first_lookups, first_lookups);
                    check_field("next_lookups", want.next_lookups, next_lookups);
                end
            end
            if (start && busy === 1'b0)
            begin
                op.op_mode  = chi_mode_t'(mode);
                op.op_key   = key;
                op.op_index = index;
                chain_replies.push_back(apply_hash_op(op));
                ops_accepted <= ops_accepted + 1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((start && busy === 1'b0) || done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // full table: empty ends, chaining, extreme keys, ignored mode
        push_op(MODE_FIRST, 32'sd0, 12'hFFF);
        push_op(MODE_NEXT, 32'sd0, 12'd0);
        push_op(MODE_ADD, 32'sd0, 12'd0);
        push_op(MODE_ADD, 32'sd1024, 12'hFFF);
        push_op(MODE_ADD, 32'h8000_0000, 12'd5);
        push_op(MODE_ADD, 32'h7FFF_FFFF, 12'd7);
        push_op(MODE_ADD, -32'sd1, 12'd9);
        push_op(MODE_FIRST, 32'sd0, 12'd0);
        push_op(MODE_NEXT, 32'sd0, 12'd5);
        push_op(MODE_NEXT, 32'sd0, 12'hFFF);
        push_op(MODE_NEXT, 32'sd0, 12'd0);
        push_op(MODE_NOP, $urandom, 12'hFFF);
        push_op(MODE_FIRST, -32'sd1025, 12'd0);

        // shrunk table: range errors and a stale head
        write_table_size(13'd8);
        push_op(MODE_ADD, 32'sd3, 12'd8);
        push_op(MODE_NEXT, 32'sd0, 12'hFFF);
        push_op(MODE_NEXT, 32'sd0, 12'd7);
        push_op(MODE_FIRST, -32'sd1, 12'd0);
        push_op(MODE_ADD, 32'sd1, 12'd7);
        push_op(MODE_NEXT, 32'sd0, 12'd7);

        write_table_size(13'd0);
        push_op(MODE_ADD, 32'sd0, 12'd0);
        push_op(MODE_NEXT, 32'sd0, 12'd0);
        push_op(MODE_FIRST, 32'h7FFF_FFFF, 12'd0);

        // oversized write saturates and clears every link
        write_table_size(13'h1FFF);
        push_op(MODE_NEXT, 32'sd0, 12'd7);
        push_op(MODE_NEXT, 32'sd0, 12'd5);
        push_op(MODE_FIRST, 32'sd0, 12'd0);

        foreach (phase_sizes[p])
        begin
            write_table_size(phase_sizes[p]);
            queue_random_ops(160);
        end

        wait_until_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
hdl/chi_pkg.sv
hdl/chi_ram.sv
hdl/chi_mod.sv
hdl/chi_ctrl.sv
hdl/chi_dpath.sv
hdl/chained_hash_index_top.sv
verif/chained_hash_index_top_tb.sv
